// File: rtl/rar_pkg.sv
// Package for the rational arithmetic reduce block: widths, operation codes
// and shared types. No dependencies.
`default_nettype none
package rar_pkg;
    localparam int OPW = 16;
    localparam int RESW = 2 * OPW + 1;
    localparam int CNTW = $clog2(RESW + 1);

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    // Request to the shared divider and its answer.
    typedef struct packed {
        logic                   start;
        logic signed [RESW-1:0] dividend;
        logic signed [RESW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic signed [RESW-1:0] quot;
        logic signed [RESW-1:0] rem;
    } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/rar_div.sv
// Restoring divider, one quotient bit per cycle, truncating signed result.
// Depends on rar_pkg.
`default_nettype none
module rar_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rar_pkg::div_req_t req,
    output rar_pkg::div_rsp_t      rsp
);
    import rar_pkg::*;

    logic [RESW-1:0] rem_reg, rem_next;
    logic [RESW-1:0] quo_reg, quo_next;
    logic [RESW-1:0] dvs_reg, dvs_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            qneg_reg, qneg_next;
    logic            rneg_reg, rneg_next;
    logic            done_reg, done_next;
    logic [RESW:0]   trial;
    logic [RESW:0]   diff;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[RESW-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (req.start)
        begin
            // Magnitudes fit in RESW bits since operands never reach -2^32.
            quo_next  = req.dividend[RESW-1] ? -req.dividend : req.dividend;
            dvs_next  = req.divisor[RESW-1] ? -req.divisor : req.divisor;
            rem_next  = '0;
            cnt_next  = CNTW'(RESW);
            busy_next = 1'b1;
            qneg_next = req.dividend[RESW-1] ^ req.divisor[RESW-1];
            rneg_next = req.dividend[RESW-1];
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[RESW-2:0], ~diff[RESW]};
            rem_next = diff[RESW] ? trial[RESW-1:0] : diff[RESW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = qneg_reg ? -quo_reg : quo_reg;
    assign rsp.rem  = rneg_reg ? -rem_reg : rem_reg;
endmodule
`default_nettype wire

// File: rtl/rational_arith_reduce_core.sv
// Top level: sequencer that forms the raw fraction with one shared multiplier
// and runs the gcd and both reductions on rar_div. Depends on rar_pkg, rar_div.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, action, a_*, b_*      | into block
//  out     | out_valid, out_stall, res_num, res_den, status | out of block
//
// An item runs through the multiply states S_M0 to S_M3, one divider run per gcd
// remainder step and two more divisions; a 0/0 result needs no division. Its
// time depends on the number of remainder steps, and most of it is spent in
// the serial divider. Reset clears control only; a held result leaves
// in_stall high until it is transferred.
`default_nettype none
module rational_arith_reduce_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   action,
    input  wire logic signed [rar_pkg::OPW-1:0] a_num,
    input  wire logic signed [rar_pkg::OPW-1:0] a_den,
    input  wire logic signed [rar_pkg::OPW-1:0] b_num,
    input  wire logic signed [rar_pkg::OPW-1:0] b_den,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [rar_pkg::RESW-1:0]   res_num,
    output logic signed [rar_pkg::RESW-1:0]   res_den,
    output logic                              status
);
    import rar_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_GCHK, S_GWAIT,
        S_DN, S_DNW, S_DD, S_DDW, S_OUT
    } state_t;

    state_t state_reg;
    logic [1:0] act_reg;
    logic signed [OPW-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [RESW-1:0] n_reg, d_reg, x_reg, y_reg, t_reg;
    logic signed [RESW-1:0] rn_reg, rd_reg;
    logic st_reg;
    logic signed [OPW-1:0] ma, mb;
    logic signed [2*OPW-1:0] prod;
    div_req_t req;
    div_rsp_t rsp;

    rar_div u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always_comb
    begin
        ma = an_reg;
        mb = bd_reg;
        case (state_reg)
            S_M0:    begin ma = an_reg; mb = (act_reg == ACT_MUL) ? bn_reg : bd_reg; end
            S_M1:    begin ma = bn_reg; mb = ad_reg; end
            S_M2:    begin ma = ad_reg; mb = (act_reg == ACT_DIV) ? bn_reg : bd_reg; end
            default: begin ma = an_reg; mb = bd_reg; end
        endcase
        prod = ma * mb;
    end

    always_comb
    begin
        req.start    = 1'b0;
        req.dividend = x_reg;
        req.divisor  = y_reg;
        case (state_reg)
            S_GCHK:  req.start = (y_reg != '0);
            S_DN:    begin req.start = 1'b1; req.dividend = n_reg; req.divisor = x_reg; end
            S_DD:    begin req.start = 1'b1; req.dividend = d_reg; req.divisor = x_reg; end
            default: req.start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        act_reg <= action;
                        an_reg <= a_num; ad_reg <= a_den;
                        bn_reg <= b_num; bd_reg <= b_den;
                        state_reg <= S_M0;
                    end
                S_M0: begin t_reg <= RESW'(prod); state_reg <= S_M1; end
                S_M1:
                begin
                    if (act_reg == ACT_ADD)
                        n_reg <= t_reg + RESW'(prod);
                    else if (act_reg == ACT_SUB)
                        n_reg <= t_reg - RESW'(prod);
                    else
                        n_reg <= t_reg;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    d_reg <= RESW'(prod);
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    x_reg <= n_reg;
                    y_reg <= d_reg;
                    state_reg <= S_GCHK;
                end
                S_GCHK:
                    if (y_reg != '0)
                        state_reg <= S_GWAIT;
                    else if (x_reg == '0)
                    begin
                        rn_reg <= '0; rd_reg <= '0; st_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_DN;
                S_GWAIT:
                    if (rsp.done)
                    begin
                        x_reg <= y_reg;
                        y_reg <= rsp.rem;
                        state_reg <= S_GCHK;
                    end
                S_DN:  state_reg <= S_DNW;
                S_DNW:
                    if (rsp.done)
                    begin
                        rn_reg <= rsp.quot;
                        state_reg <= S_DD;
                    end
                S_DD:  state_reg <= S_DDW;
                S_DDW:
                    if (rsp.done)
                    begin
                        rd_reg <= rsp.quot;
                        st_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                S_OUT:
                    if (!out_stall)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign res_num   = rn_reg;
    assign res_den   = rd_reg;
    assign status    = st_reg;
endmodule
`default_nettype wire

// File: rtl/rar_checker.sv
// Port-level checker for rational_arith_reduce_core, bound to the top level.
// Depends on rar_pkg.
`default_nettype none
module rar_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic signed [rar_pkg::RESW-1:0] res_num,
    input wire logic signed [rar_pkg::RESW-1:0] res_den,
    input wire logic                       status
);
    import rar_pkg::*;

    a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> res_num == '0 && res_den == '0)
        else $error("error status without 0/0");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result held");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !out_valid)
        else $error("no work after accepted transfer");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(res_num))
        else $error("stalled result changed");
endmodule

bind rational_arith_reduce_core rar_checker u_rar_checker (.*);
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for rational_arith_reduce_core: a transfer scoreboard
// predicts each reduced fraction and compares it with the block's output.
// Depends on rar_pkg and the RTL of the block.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rar_pkg::*;

    localparam int  N_RANDOM   = 1530;
    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam int  DRAIN_CYCLES = 4000;

    typedef struct {
        logic signed [RESW-1:0] num;
        logic signed [RESW-1:0] den;
        logic                   zero_gcd;
    } fraction_t;

    class fraction_scoreboard;
        fraction_t pending_q[$];
        int        n_errors;

        // Euclid with truncating remainder; the sign of the gcd follows from it.
        function longint trunc_gcd(longint x, longint y);
            longint r;
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        function fraction_t reduce_fraction(action_t act, longint an, longint ad,
                                            longint bn, longint bd);
            longint    n;
            longint    d;
            longint    g;
            fraction_t f;
            case (act)
                ACT_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
                ACT_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
                ACT_MUL: begin n = an * bn;           d = ad * bd; end
                default: begin n = an * bd;           d = ad * bn; end
            endcase
            g = trunc_gcd(n, d);
            if (g == 0)
            begin
                f.num = '0;
                f.den = '0;
                f.zero_gcd = 1'b1;
            end
            else
            begin
                f.num = RESW'(n / g);
                f.den = RESW'(d / g);
                f.zero_gcd = 1'b0;
            end
            return f;
        endfunction

        function void note_input(action_t act, logic signed [OPW-1:0] an,
                                 logic signed [OPW-1:0] ad, logic signed [OPW-1:0] bn,
                                 logic signed [OPW-1:0] bd);
            pending_q.push_back(reduce_fraction(act, an, ad, bn, bd));
        endfunction

        function void check_result(logic signed [RESW-1:0] num,
                                   logic signed [RESW-1:0] den, logic st);
            fraction_t e;
            if (pending_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected result %0d/%0d status %0b", num, den, st);
                return;
            end
            e = pending_q.pop_front();
            if (num !== e.num || den !== e.den || st !== e.zero_gcd)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: expected %0d/%0d status %0b, got %0d/%0d status %0b",
                             e.num, e.den, e.zero_gcd, num, den, st);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             action;
    logic signed [OPW-1:0]  a_num;
    logic signed [OPW-1:0]  a_den;
    logic signed [OPW-1:0]  b_num;
    logic signed [OPW-1:0]  b_den;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [RESW-1:0] res_num;
    logic signed [RESW-1:0] res_den;
    logic                   status;

    fraction_scoreboard sb;
    bit     quiet_mode;
    int     stall_left;
    longint cycle_count;

    rational_arith_reduce_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .res_num  (res_num),
        .res_den  (res_den),
        .status   (status)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_ADD;
        a_num = '0;
        a_den = '0;
        b_num = '0;
        b_den = '0;
        out_stall = 1'b0;
        stall_left = 0;
        quiet_mode = 1'b0;
        cycle_count = 0;
        sb = new();
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure in random bursts, switched off near the end.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (!quiet_mode && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 14);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(res_num, res_den, status);
    end

    function automatic logic signed [OPW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return OPW'(-(1 << (OPW - 1)));
            1: return OPW'((1 << (OPW - 1)) - 1);
            2: return '0;
            3, 4: return OPW'(int'($urandom_range(0, 16)) - 8);
            default: return OPW'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_fraction_pair(action_t act, logic signed [OPW-1:0] an,
                                      logic signed [OPW-1:0] ad,
                                      logic signed [OPW-1:0] bn,
                                      logic signed [OPW-1:0] bd);
        int gap;
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action <= act;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(act, an, ad, bn, bd);
        @(negedge clk);
    endtask

    task automatic send_random();
        send_fraction_pair(action_t'($urandom_range(0, 3)), pick_operand(),
                           pick_operand(), pick_operand(), pick_operand());
    endtask

    task automatic wait_for_drain();
        while (sb.pending_q.size() != 0)
            @(negedge clk);
    endtask

    localparam logic signed [OPW-1:0] MINV = OPW'(-(1 << (OPW - 1)));
    localparam logic signed [OPW-1:0] MAXV = OPW'((1 << (OPW - 1)) - 1);

    initial
    begin
        #0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every operation, extremes, zero gcd and zero denominators.
        send_fraction_pair(ACT_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_fraction_pair(ACT_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
        send_fraction_pair(ACT_MUL, 16'sd2, 16'sd3, -16'sd3, 16'sd4);
        send_fraction_pair(ACT_DIV, 16'sd2, 16'sd3, 16'sd4, -16'sd9);
        send_fraction_pair(ACT_ADD, MINV, MINV, MINV, MINV);
        send_fraction_pair(ACT_SUB, MINV, MAXV, MAXV, MINV);
        send_fraction_pair(ACT_MUL, MINV, MINV, MINV, MINV);
        send_fraction_pair(ACT_DIV, MAXV, MINV, MINV, MAXV);
        send_fraction_pair(ACT_ADD, MAXV, MAXV, MAXV, MAXV);
        send_fraction_pair(ACT_MUL, MAXV, 16'sd1, MINV, 16'sd1);
        send_fraction_pair(ACT_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_fraction_pair(ACT_MUL, 16'sd0, 16'sd0, 16'sd5, 16'sd7);
        send_fraction_pair(ACT_DIV, 16'sd0, 16'sd3, 16'sd0, 16'sd5);
        send_fraction_pair(ACT_SUB, 16'sd3, 16'sd0, 16'sd5, 16'sd7);
        send_fraction_pair(ACT_ADD, -16'sd3, 16'sd0, 16'sd5, 16'sd7);
        send_fraction_pair(ACT_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd7);
        send_fraction_pair(ACT_MUL, -16'sd6, 16'sd4, 16'sd1, -16'sd1);
        send_fraction_pair(ACT_SUB, -16'sd1, -16'sd1, 16'sd1, 16'sd1);
        send_fraction_pair(ACT_DIV, MINV, -16'sd1, -16'sd1, MINV);
        send_fraction_pair(ACT_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
                wait_for_drain();
            if (i == N_RANDOM - 150)
                quiet_mode = 1'b1;
            send_random();
        end
        in_valid <= 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

// File: rational_arith_reduce_core.f
rtl/rar_pkg.sv
rtl/rar_div.sv
rtl/rational_arith_reduce_core.sv
rtl/rar_checker.sv
tb/tb_top.sv
